/* hdl/lion_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lion_pkg
// Shared types, constants and saturation helper for the Lion update block.
// ----------------------------------------------------------------------------
package lion_pkg;

    localparam int IDX_W   = 12;
    localparam int WORD_W  = 32;
    localparam int LR_W    = 24;
    localparam int BETA_W  = 17;
    localparam int WD_W    = 16;
    localparam int CFG_DW  = 24;
    localparam int CFG_IW  = 2;

    localparam logic [BETA_W-1:0] BETA_ONE = 17'd65536;

    localparam logic [LR_W-1:0]   LR_RST   = 24'd1678;
    localparam logic [BETA_W-1:0] B1_RST   = 17'd58982;
    localparam logic [BETA_W-1:0] B2_RST   = 17'd64880;
    localparam logic [WD_W-1:0]   WD_RST   = 16'd0;

    localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;

    localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
    localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

    typedef enum logic [CFG_IW-1:0] {
        CFG_LR        = 2'd0,
        CFG_BETA_MIX  = 2'd1,
        CFG_BETA_KEEP = 2'd2,
        CFG_DECAY     = 2'd3
    } t_cfg_idx;

    // Config as seen by the datapath: betas already clipped to one.
    typedef struct packed {
        logic [LR_W-1:0]   lr;
        logic [BETA_W-1:0] b1;
        logic [BETA_W-1:0] b1_cmp;
        logic [BETA_W-1:0] b2;
        logic [BETA_W-1:0] b2_cmp;
        logic              wd_on;
        logic [LR_W-1:0]   k;
    } t_cfg;

    function automatic logic signed [WORD_W-1:0] sat_w(input logic signed [50:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > SAT_HI) begin
            r = W_MAX;
        end else if (x < SAT_LO) begin
            r = W_MIN;
        end else begin
            r = $signed(x[WORD_W-1:0]);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/lion_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lion_cfg_regs
// Configuration registers, beta clipping and the decay factor k = lr*wd.
// ----------------------------------------------------------------------------
module lion_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [lion_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [lion_pkg::CFG_DW-1:0]  i_cfg_data,
    output lion_pkg::t_cfg                    o_cfg
);
    import lion_pkg::*;

    logic [LR_W-1:0]   r_lr;
    logic [BETA_W-1:0] r_b1;
    logic [BETA_W-1:0] r_b2;
    logic [WD_W-1:0]   r_wd;
    logic [LR_W-1:0]   r_k;
    logic [39:0]       w_kp;
    logic [BETA_W-1:0] w_b1c;
    logic [BETA_W-1:0] w_b2c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LR_RST;
            r_b1 <= B1_RST;
            r_b2 <= B2_RST;
            r_wd <= WD_RST;
            r_k  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_LR:        r_lr <= i_cfg_data;
                    CFG_BETA_MIX:  r_b1 <= i_cfg_data[BETA_W-1:0];
                    CFG_BETA_KEEP: r_b2 <= i_cfg_data[BETA_W-1:0];
                    CFG_DECAY:     r_wd <= i_cfg_data[WD_W-1:0];
                endcase
            end
            // k is registered from the stored lr and decay values, so it updates after them
            r_k <= w_kp[39:16];
        end
    end

    assign w_kp  = 40'(r_lr) * 40'(r_wd);
    assign w_b1c = (r_b1 > BETA_ONE) ? BETA_ONE : r_b1;
    assign w_b2c = (r_b2 > BETA_ONE) ? BETA_ONE : r_b2;

    always_comb begin
        o_cfg.lr     = r_lr;
        o_cfg.b1     = w_b1c;
        o_cfg.b1_cmp = BETA_ONE - w_b1c;
        o_cfg.b2     = w_b2c;
        o_cfg.b2_cmp = BETA_ONE - w_b2c;
        o_cfg.wd_on  = (r_wd != '0);
        o_cfg.k      = r_k;
    end

endmodule
`default_nettype wire

/* hdl/lion_mom_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lion_mom_store
// Momentum memory: one write port, one registered read port, zero sweep
// after reset.
// ----------------------------------------------------------------------------
module lion_mom_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_rd_en,
    input  wire logic [AW-1:0]                      i_rd_addr,
    output logic signed [lion_pkg::WORD_W-1:0]      o_rd_data,
    input  wire logic                               i_wr_en,
    input  wire logic [AW-1:0]                      i_wr_addr,
    input  wire logic signed [lion_pkg::WORD_W-1:0] i_wr_data,
    output logic                                    o_busy
);
    import lion_pkg::*;

    logic signed [WORD_W-1:0] r_mem [0:DEPTH-1];
    logic signed [WORD_W-1:0] r_rd;
    logic                     r_busy;
    logic [AW-1:0]            r_clr_addr;
    logic                     w_we;
    logic [AW-1:0]            w_wa;
    logic signed [WORD_W-1:0] w_wd;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == LAST) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign w_we = r_busy || i_wr_en;
    assign w_wa = r_busy ? r_clr_addr : i_wr_addr;
    assign w_wd = r_busy ? '0 : i_wr_data;

    // read-during-write returns old data; the pipeline forwards around it
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_busy;

    a_no_wr_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && i_wr_en))
        else $error("pipeline write during clear sweep");

    a_clr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_clr_addr <= LAST))
        else $error("clear address past depth");

    a_clr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> ($past(r_clr_addr) == LAST))
        else $error("clear sweep ended early");

endmodule
`default_nettype wire

/* hdl/lion_optimizer_update.sv */
// Pipeline: an accepted request passes stage 0, stage 1, stage 2 and the output register.
// Throughput: one request per cycle when not stalled; a request whose momentum
//   slot matches the one right ahead waits for its write-back (read two
//   stages ahead of write-back, forwarding covers the gap beyond one stage).
// Reset: config returns to defaults; momentum is zeroed by a sweep over
//   all ELEMENT_COUNT entries, one entry per cycle, with o_stall held high.
`default_nettype none
// ----------------------------------------------------------------------------
// lion_optimizer_update
// Lion optimizer step per weight element with per-element momentum memory.
// ----------------------------------------------------------------------------
module lion_optimizer_update #(
    parameter int ELEMENT_COUNT = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config write port
    input  wire logic                               i_cfg_we,
    input  wire logic [lion_pkg::CFG_IW-1:0]        i_cfg_index,
    input  wire logic [lion_pkg::CFG_DW-1:0]        i_cfg_data,
    // request channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [lion_pkg::IDX_W-1:0]         i_element_index,
    input  wire logic signed [lion_pkg::WORD_W-1:0] i_weight_in,
    input  wire logic signed [lion_pkg::WORD_W-1:0] i_gradient,
    // result channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [lion_pkg::IDX_W-1:0]              o_result_index,
    output logic signed [lion_pkg::WORD_W-1:0]      o_weight_out
);
    import lion_pkg::*;

    localparam int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

    localparam logic signed [56:0] DEC_RND = 57'sd8388608;  // 2^23
    localparam logic signed [50:0] MOM_RND = 51'sd32768;    // 2^15

    t_cfg cfg;

    // ---------------- stage 0: captured request, slot reduce, decay product
    logic                     r_v0;
    logic [IDX_W-1:0]         r_idx0;
    logic signed [WORD_W-1:0] r_w0;
    logic signed [WORD_W-1:0] r_g0;
    logic [AW-1:0]            w_slot0;
    logic signed [56:0]       w_p0;

    // ---------------- stage 1: memory data, decay apply, beta products
    logic                     r_v1;
    logic [IDX_W-1:0]         r_idx1;
    logic [AW-1:0]            r_slot1;
    logic signed [WORD_W-1:0] r_w1raw;
    logic signed [WORD_W-1:0] r_g1;
    logic signed [56:0]       r_p1;
    logic                     r_fsel1;
    logic signed [WORD_W-1:0] r_fm1;
    logic signed [WORD_W-1:0] w_rd;
    logic signed [WORD_W-1:0] w_m1;
    logic signed [56:0]       w_dsum;
    logic signed [56:0]       w_d;
    logic signed [WORD_W-1:0] w_w1;

    // ---------------- stage 2: sums, sign, momentum write-back
    logic                     r_v2;
    logic [IDX_W-1:0]         r_idx2;
    logic [AW-1:0]            r_slot2;
    logic signed [WORD_W-1:0] r_w2;
    logic signed [49:0]       r_pa2;
    logic signed [49:0]       r_pb2;
    logic signed [49:0]       r_qa2;
    logic signed [49:0]       r_qb2;
    logic signed [50:0]       w_c;
    logic signed [50:0]       w_msum;
    logic signed [WORD_W-1:0] w_mnew;
    logic signed [WORD_W-1:0] w_wp;
    logic signed [WORD_W-1:0] w_wn;
    logic signed [WORD_W-1:0] w_wsel;

    // ---------------- output register
    logic                     r_ov;
    logic [IDX_W-1:0]         r_oidx;
    logic signed [WORD_W-1:0] r_ow;

    // ---------------- flow control
    logic w_busy;
    logic w_en_out;
    logic w_en2;
    logic w_en1;
    logic w_en0;
    logic w_wr2;
    logic w_hazard;
    logic w_mv01;
    logic w_acc;

    lion_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lion_mom_store #(
        .DEPTH (ELEMENT_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_en1),
        .i_rd_addr (w_slot0),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr2),
        .i_wr_addr (r_slot2),
        .i_wr_data (w_mnew),
        .o_busy    (w_busy)
    );

    // Each stage loads when it is empty or the one after it moves, so
    // bubbles collapse and requests keep coming while a result waits.
    assign w_en_out = !r_ov || !i_stall;
    assign w_wr2    = r_v2 && w_en_out;
    assign w_en2    = !r_v2 || w_en_out;
    assign w_en1    = !r_v1 || w_en2;

    // Same slot still in flight: stage 1 always blocks; stage 2 blocks
    // unless it writes back this edge, in which case its result is forwarded.
    assign w_hazard = r_v0 && ((r_v1 && (r_slot1 == w_slot0)) ||
                               (r_v2 && (r_slot2 == w_slot0) && !w_wr2));
    assign w_mv01   = r_v0 && w_en1 && !w_hazard;
    assign w_en0    = !r_v0 || w_mv01;
    assign o_stall  = w_busy || !w_en0;
    assign w_acc    = i_valid && !o_stall;

    // Index to slot. Below 4096 entries the index is reduced with a
    // reciprocal multiply at capture and a constant multiply-subtract here.
    generate
        if (ELEMENT_COUNT < 4096) begin : g_mod
            localparam logic [24:0] RECIP =
                25'((2**24 + ELEMENT_COUNT - 1) / ELEMENT_COUNT);
            logic [36:0]      w_qp;
            logic [IDX_W-1:0] r_q0;
            assign w_qp = 37'(i_element_index) * 37'(RECIP);
            always_ff @(posedge i_clk) begin
                if (w_acc) begin
                    r_q0 <= w_qp[35:24];
                end
            end
            assign w_slot0 = AW'(r_idx0 - 12'(r_q0 * 12'(ELEMENT_COUNT)));
        end else begin : g_direct
            assign w_slot0 = AW'(r_idx0);
        end
    endgenerate

    assign w_p0 = 57'(r_w0) * 57'($signed({1'b0, cfg.k}));

    // stage 1 arithmetic: decoupled decay, round half up
    assign w_m1   = r_fsel1 ? r_fm1 : w_rd;
    assign w_dsum = r_p1 + DEC_RND;
    assign w_d    = w_dsum >>> 24;
    assign w_w1   = cfg.wd_on ? sat_w(51'(r_w1raw) - 51'(w_d)) : r_w1raw;

    // stage 2 arithmetic
    assign w_c    = 51'(r_pa2) + 51'(r_pb2);
    assign w_msum = 51'(r_qa2) + 51'(r_qb2) + MOM_RND;
    assign w_mnew = sat_w(w_msum >>> 16);
    assign w_wp   = sat_w(51'(r_w2) - 51'($signed({1'b0, cfg.lr})));
    assign w_wn   = sat_w(51'(r_w2) + 51'($signed({1'b0, cfg.lr})));

    always_comb begin
        priority if (w_c[50]) begin
            w_wsel = w_wn;
        end else if (w_c != '0) begin
            w_wsel = w_wp;
        end else begin
            w_wsel = r_w2;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= w_acc;
            end
            if (w_en1) begin
                r_v1 <= w_mv01;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en_out) begin
                r_ov <= r_v2;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_idx0 <= i_element_index;
            r_w0   <= i_weight_in;
            r_g0   <= i_gradient;
        end
        if (w_en1) begin
            r_idx1  <= r_idx0;
            r_slot1 <= w_slot0;
            r_w1raw <= r_w0;
            r_g1    <= r_g0;
            r_p1    <= w_p0;
            r_fsel1 <= w_wr2 && (r_slot2 == w_slot0);
            r_fm1   <= w_mnew;
        end
        if (w_en2) begin
            r_idx2  <= r_idx1;
            r_slot2 <= r_slot1;
            r_w2    <= w_w1;
            r_pa2   <= 50'(w_m1) * 50'($signed({1'b0, cfg.b1}));
            r_pb2   <= 50'(r_g1) * 50'($signed({1'b0, cfg.b1_cmp}));
            r_qa2   <= 50'(w_m1) * 50'($signed({1'b0, cfg.b2}));
            r_qb2   <= 50'(r_g1) * 50'($signed({1'b0, cfg.b2_cmp}));
        end
        if (w_en_out) begin
            r_oidx <= r_idx2;
            r_ow   <= w_wsel;
        end
    end

    assign o_valid        = r_ov;
    assign o_result_index = r_oidx;
    assign o_weight_out   = r_ow;

    a_no_slot_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v1 && r_v2 && (r_slot1 == r_slot2)))
        else $error("two in-flight requests share a momentum slot");

    a_empty_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> (!r_v0 && !r_v1 && !r_v2 && !r_ov))
        else $error("request in flight during clear sweep");

    a_wb_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr2 |=> r_ov)
        else $error("momentum written without a result");

endmodule
`default_nettype wire
